### rtl/cpmc_pkg.sv
// ----------------------------------------------------------------------------
// cpmc_pkg
// shared types, constants and helpers for the cascaded pi motor controller
// ----------------------------------------------------------------------------
package cpmc_pkg;

  // duty constants, unsigned q0.16
  localparam logic [15:0] DUTY_HALF = 16'd32768;
  localparam logic [15:0] DUTY_MIN  = 16'd1311;
  localparam logic [15:0] DUTY_MAX  = 16'd64225;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_I   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_P = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_I = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CUR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLT  = 3'd6;

  // serial unit widths
  localparam int MUL_W  = 32;
  localparam int RES_W  = 45;
  localparam int SUM_W  = 46;
  localparam int QUOT_W = 48;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CERR, S_CMP, S_CMT, S_CMI, S_SPD, S_SMP,
    S_SMT, S_SMI, S_SMV, S_DUTY, S_DIV, S_OUT
  } state_t;

  // request to the serial multiplier
  typedef struct packed {
    logic                    start;
    logic                    sh20;
    logic signed [MUL_W-1:0] a;
    logic [MUL_W-1:0]        b;
  } mul_req_t;

  // request to the serial divider
  typedef struct packed {
    logic        start;
    logic [31:0] mag;
    logic [30:0] divisor;
  } div_req_t;

  // saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > 46'sd2147483647) r = 32'sh7fffffff;
    else if (v < -46'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/cpmc_mul.sv
// ----------------------------------------------------------------------------
// cpmc_mul
// bit-serial sign-magnitude multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module cpmc_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cpmc_pkg::mul_req_t                    req,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [cpmc_pkg::RES_W-1:0]     result
);
  import cpmc_pkg::*;

  logic [MUL_W-1:0] mag;
  logic [MUL_W-1:0] hi;
  logic [MUL_W-1:0] lo;
  logic [5:0]       cnt;
  logic             neg;
  logic             sh20;
  logic [MUL_W:0]   sum;
  logic [RES_W-1:0] magw;

  // one shift-add step
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mag} : {(MUL_W+1){1'b0}});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and product
  always_ff @(posedge clk) begin
    if (req.start) begin
      mag  <= req.a[MUL_W-1] ? MUL_W'(-req.a) : MUL_W'(req.a);
      neg  <= req.a[MUL_W-1];
      sh20 <= req.sh20;
      hi   <= '0;
      lo   <= req.b;
    end else if (busy) begin
      hi <= sum[MUL_W:1];
      lo <= {sum[0], lo[MUL_W-1:1]};
    end
  end

  // scale and restore sign
  assign magw   = sh20 ? {1'b0, hi, lo[MUL_W-1:20]} : {13'd0, hi};
  assign result = neg ? -$signed(magw) : $signed(magw);

endmodule

### rtl/cpmc_div.sv
// ----------------------------------------------------------------------------
// cpmc_div
// restoring divider, one quotient bit per cycle, for the duty ratio
// ----------------------------------------------------------------------------
module cpmc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  cpmc_pkg::div_req_t                req,
  output logic                              done,
  output logic [cpmc_pkg::QUOT_W-1:0]       quot
);
  import cpmc_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [30:0] dvs;
  logic [32:0] t;
  logic        ge;

  // trial subtract
  assign t  = {rem, quot[QUOT_W-1]};
  assign ge = t >= {2'b00, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      dvs  <= req.divisor;
      quot <= {req.mag, 16'd0};
    end else if (busy) begin
      rem  <= ge ? 32'(t - {2'b00, dvs}) : t[31:0];
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

endmodule

### rtl/cascaded_pi_motor_controller.sv
// path: an out-of-range motor goes straight to the output; with both loops and the
// duty stage on, an item takes six serial multiplies and one divide
// throughput: one item at a time; the next item is taken once the result is in
// the output register
// reset: gains and limits to their defaults, integrators and commands to zero,
// held duty to half
// ----------------------------------------------------------------------------
// cascaded_pi_motor_controller
// per-motor cascaded speed and current pi loops with anti-windup and duty output
// ----------------------------------------------------------------------------
module cascaded_pi_motor_controller #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        motor_index,
  input  logic [2:0]                        mode,
  input  logic signed [31:0]                speed_request,
  input  logic signed [31:0]                speed_measured,
  input  logic signed [31:0]                current_request,
  input  logic signed [31:0]                current_measured,
  input  logic signed [31:0]                voltage_request,
  input  logic [30:0]                       dc_link_voltage,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        motor_id,
  output logic [15:0]                       duty_cycle,
  output logic signed [31:0]                voltage_command,
  output logic signed [31:0]                current_command
);
  import cpmc_pkg::*;

  localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // configuration
  logic [31:0] spg, sig, cpg, cig, sp;
  logic [30:0] imax, vmax;

  // per-motor state
  logic signed [31:0] s_int [MOTOR_COUNT];
  logic signed [31:0] c_int [MOTOR_COUNT];
  logic signed [31:0] s_cmd [MOTOR_COUNT];
  logic [15:0]        h_duty [MOTOR_COUNT];

  // item registers
  state_t             state, state_next;
  logic [1:0]         m_r;
  logic [2:0]         mode_r;
  logic signed [31:0] sreq, smeas, cmeas, volt;
  logic [30:0]        vdc_r;
  logic               bad;
  logic signed [31:0] ci, si, sc, err, icand;
  logic [15:0]        hd;
  logic signed [RES_W-1:0] pval;
  logic               issued;
  logic [IW-1:0]      idx;

  // serial units
  mul_req_t                mul_req;
  logic                    mul_busy, mul_done;
  logic signed [RES_W-1:0] mul_res;
  div_req_t                div_req;
  logic                    div_done;
  logic [QUOT_W-1:0]       quot;

  logic                    spd_on, cur_on, dut_on, mul_state, out_load;
  logic signed [SUM_W-1:0] dsum, vmax_s, imax_s, integ_sum;
  logic signed [31:0]      vclamp;
  logic                    vhold, chold;
  logic signed [31:0]      cclamp;
  logic [15:0]             duty_div;
  logic [16:0]             dsig;

  assign spd_on = mode_r[0];
  assign cur_on = mode_r[1];
  assign dut_on = mode_r[2];
  assign idx    = IW'(m_r);
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  cpmc_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  cpmc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spg  <= 32'd336;
      sig  <= 32'd197;
      cpg  <= 32'd2778726;
      cig  <= 32'd1279451464;
      sp   <= 32'd4294967;
      imax <= 31'd131072000;
      vmax <= 31'd786432;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPEED_P:   spg  <= cfg_data;
        REG_SPEED_I:   sig  <= cfg_data;
        REG_CURRENT_P: cpg  <= cfg_data;
        REG_CURRENT_I: cig  <= cfg_data;
        REG_PERIOD:    sp   <= cfg_data;
        REG_MAX_CUR:   imax <= cfg_data[30:0];
        REG_MAX_VOLT:  vmax <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and unit requests
  always_comb begin
    state_next  = state;
    mul_state   = 1'b0;
    mul_req.sh20 = 1'b1;
    mul_req.a   = err;
    mul_req.b   = cpg;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_LOAD;
      S_LOAD: begin
        if (bad)         state_next = S_OUT;
        else if (cur_on) state_next = S_CERR;
        else             state_next = S_SPD;
      end
      S_CERR: state_next = S_CMP;
      S_CMP: begin
        mul_state = 1'b1;
        if (mul_done) state_next = S_CMT;
      end
      S_CMT: begin
        mul_state = 1'b1;
        mul_req.sh20 = 1'b0;
        mul_req.b = sp;
        if (mul_done) state_next = S_CMI;
      end
      S_CMI: begin
        mul_state = 1'b1;
        mul_req.a = icand;
        mul_req.b = cig;
        if (mul_done) state_next = S_SPD;
      end
      S_SPD: state_next = spd_on ? S_SMP : S_DUTY;
      S_SMP: begin
        mul_state = 1'b1;
        mul_req.b = spg;
        if (mul_done) state_next = cur_on ? S_SMT : S_SMV;
      end
      S_SMT: begin
        mul_state = 1'b1;
        mul_req.sh20 = 1'b0;
        mul_req.b = sp;
        if (mul_done) state_next = S_SMI;
      end
      S_SMI: begin
        mul_state = 1'b1;
        mul_req.a = icand;
        mul_req.b = sig;
        if (mul_done) state_next = S_DUTY;
      end
      S_SMV: begin
        mul_state = 1'b1;
        mul_req.a = si;
        mul_req.b = sig;
        if (mul_done) state_next = S_DUTY;
      end
      S_DUTY: state_next = (dut_on && vdc_r != 31'd0) ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_next = S_OUT;
      S_OUT:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    mul_req.start   = mul_state && !issued;
    div_req.start   = (state == S_DUTY) && dut_on && (vdc_r != 31'd0);
    div_req.mag     = volt[31] ? 32'(-volt) : 32'(volt);
    div_req.divisor = vdc_r;
  end

  // multiplier issue flag
  always_ff @(posedge clk) begin
    if (rst)                issued <= 1'b0;
    else if (mul_done)      issued <= 1'b0;
    else if (mul_req.start) issued <= 1'b1;
  end

  // sums and clamps
  assign dsum      = SUM_W'(pval) + SUM_W'(mul_res);
  assign integ_sum = ((state == S_CMT) ? SUM_W'(ci) : SUM_W'(si)) + SUM_W'(mul_res);
  assign vmax_s    = $signed({15'd0, vmax});
  assign imax_s    = $signed({15'd0, imax});

  always_comb begin
    vhold = 1'b0;
    if (dsum > vmax_s) begin
      vclamp = $signed({1'b0, vmax});
      vhold  = !err[31] && err != 32'sd0;
    end else if (dsum < -vmax_s) begin
      vclamp = -$signed({1'b0, vmax});
      vhold  = err[31];
    end else begin
      vclamp = dsum[31:0];
    end
    chold = 1'b0;
    if (dsum > imax_s) begin
      cclamp = $signed({1'b0, imax});
      chold  = !err[31] && err != 32'sd0;
    end else if (dsum < 46'sd0) begin
      cclamp = 32'sd0;
      chold  = err[31];
    end else begin
      cclamp = dsum[31:0];
    end
  end

  // quotient to duty
  always_comb begin
    dsig = volt[31] ? 17'(DUTY_HALF) - {2'b00, quot[14:0]}
                    : 17'(DUTY_HALF) + {2'b00, quot[14:0]};
    if (quot[QUOT_W-1:15] != '0)     duty_div = volt[31] ? DUTY_MIN : DUTY_MAX;
    else if (dsig > 17'(DUTY_MAX))   duty_div = DUTY_MAX;
    else if (dsig < 17'(DUTY_MIN))   duty_div = DUTY_MIN;
    else                             duty_div = dsig[15:0];
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      m_r    <= motor_index;
      mode_r <= mode;
      sreq   <= speed_request;
      smeas  <= speed_measured;
      sc     <= current_request;
      cmeas  <= current_measured;
      volt   <= voltage_request;
      vdc_r  <= dc_link_voltage;
      bad    <= !(32'(motor_index) < MOTOR_COUNT);
    end
    case (state)
      S_LOAD: if (!bad) begin
        ci <= cur_on ? c_int[idx] : 32'sd0;
        si <= spd_on ? s_int[idx] : 32'sd0;
        if (spd_on) sc <= s_cmd[idx];
        hd <= h_duty[idx];
      end
      S_CERR: err <= sat32(SUM_W'(sc) - SUM_W'(cmeas));
      S_CMP, S_SMP: if (mul_done) pval <= mul_res;
      S_CMT, S_SMT: if (mul_done) icand <= sat32(integ_sum);
      S_CMI: if (mul_done) begin
        volt <= vclamp;
        if (!vhold) ci <= icand;
      end
      S_SPD: if (spd_on) err <= sat32(SUM_W'(sreq) - SUM_W'(smeas));
      S_SMI: if (mul_done) begin
        sc <= cclamp;
        if (!chold) si <= icand;
      end
      S_SMV: if (mul_done) volt <= vclamp;
      S_DUTY: if (dut_on && vdc_r == 31'd0) begin
        if (volt[31])            hd <= DUTY_MIN;
        else if (volt != 32'sd0) hd <= DUTY_MAX;
        else                     hd <= DUTY_HALF;
      end
      S_DIV: if (div_done) hd <= duty_div;
      default: ;
    endcase
  end

  // per-motor state write back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        s_int[i]  <= 32'sd0;
        c_int[i]  <= 32'sd0;
        s_cmd[i]  <= 32'sd0;
        h_duty[i] <= DUTY_HALF;
      end
    end else if (out_load && !bad) begin
      s_int[idx]  <= si;
      c_int[idx]  <= ci;
      s_cmd[idx]  <= sc;
      h_duty[idx] <= hd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      motor_id        <= m_r;
      duty_cycle      <= bad ? DUTY_HALF : hd;
      voltage_command <= bad ? 32'sd0 : volt;
      current_command <= bad ? 32'sd0 : sc;
    end
  end

  // checks
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> vdc_r != 31'd0)
    else $error("divide started with zero dc link");

  a_cmd_positive: assert property (@(posedge clk) disable iff (rst)
    (state == S_SMI && mul_done) |=> !sc[31])
    else $error("current command negative after speed loop");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    (out_load && !bad) |-> ((hd >= DUTY_MIN && hd <= DUTY_MAX) || hd == DUTY_HALF))
    else $error("held duty out of range");

endmodule
